// ===== rtl/bmhq_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the binary min-heap priority queue.
package bmhq_pkg;

  localparam int CAPACITY_DEF   = 1024;
  localparam int SCORE_BITS_DEF = 32;
  localparam int TAG_BITS_DEF   = 32;

  localparam int FUNC_W   = 3;
  localparam int VALUE_W  = 32;
  localparam int SCORE_W  = 32;
  localparam int INDEX_W  = 10;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 11;
  localparam int LIMIT_W  = 11;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 11'd1024;

  typedef enum logic [FUNC_W-1:0] {
    FN_PUSH    = 3'd0,
    FN_POP     = 3'd1,
    FN_PUSHPOP = 3'd2,
    FN_PEEK    = 3'd3,
    FN_LOOKUP  = 3'd4
  } func_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK        = 2'd0,
    STAT_OVERFLOW  = 2'd1,
    STAT_UNDERFLOW = 2'd2,
    STAT_RANGE     = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROOT_RD,
    ST_ROOT_LD,
    ST_UP_RD,
    ST_UP_CMP,
    ST_DN_RD,
    ST_DN_CMP,
    ST_RESP
  } state_t;

endpackage

// ===== rtl/bmhq_store.sv =====
`timescale 1ns / 1ps
// Heap entry memory with one write port and two registered read ports.
module bmhq_store import bmhq_pkg::*; #(
  parameter int DEPTH = CAPACITY_DEF,
  parameter int WIDTH = SCORE_BITS_DEF + TAG_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
  output logic [WIDTH-1:0]         rd_data_a,
  output logic [WIDTH-1:0]         rd_data_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_a <= mem[rd_addr_a];
    rd_data_b <= mem[rd_addr_b];
  end

endmodule

// ===== rtl/bmhq_ctrl.sv =====
`timescale 1ns / 1ps
// Request sequencer with sift-up and sift-down over the heap memory.
module bmhq_ctrl import bmhq_pkg::*; #(
  parameter int CAPACITY   = CAPACITY_DEF,
  parameter int SCORE_BITS = SCORE_BITS_DEF,
  parameter int TAG_BITS   = TAG_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic [FUNC_W-1:0]                 func,
  input  logic [VALUE_W-1:0]                item_value,
  input  logic signed [SCORE_W-1:0]         item_score,
  input  logic [INDEX_W-1:0]                entry_index,
  output logic                              done,
  output logic [STATUS_W-1:0]               status,
  output logic [VALUE_W-1:0]                out_value,
  output logic signed [SCORE_W-1:0]         out_score,
  output logic [COUNT_W-1:0]                entry_count,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [LIMIT_W-1:0]                capacity_limit,
  output logic                              wr_en,
  output logic [$clog2(CAPACITY)-1:0]       wr_addr,
  output logic [SCORE_BITS+TAG_BITS-1:0]    wr_data,
  output logic [$clog2(CAPACITY)-1:0]       rd_addr_a,
  output logic [$clog2(CAPACITY)-1:0]       rd_addr_b,
  input  logic [SCORE_BITS+TAG_BITS-1:0]    rd_data_a,
  input  logic [SCORE_BITS+TAG_BITS-1:0]    rd_data_b
);

  localparam int ENTRY_W = SCORE_BITS + TAG_BITS;
  localparam int IDX_W   = $clog2(CAPACITY);
  localparam int CNT_W   = $clog2(CAPACITY + 1);
  localparam int CH_W    = IDX_W + 2;
  localparam int LCMP_W  = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;
  localparam int ICMP_W  = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;

  state_t               state;
  state_t               state_next;
  logic [CNT_W-1:0]     count;
  logic [CNT_W-1:0]     count_next;
  logic [LIMIT_W-1:0]   limit;
  func_t                fn;
  func_t                fn_in;
  logic [ENTRY_W-1:0]   item;
  logic [ENTRY_W-1:0]   item_in;
  logic [INDEX_W-1:0]   idx;
  logic [IDX_W-1:0]     at;
  logic [ENTRY_W-1:0]   cur;
  status_t              res_status;
  logic [ENTRY_W-1:0]   res_entry;

  logic                 accept;
  logic                 full;
  logic                 empty;
  logic                 oob;
  logic signed [SCORE_BITS-1:0] cur_score;
  logic signed [SCORE_BITS-1:0] a_score;
  logic signed [SCORE_BITS-1:0] b_score;
  logic signed [SCORE_BITS-1:0] pick_score;
  logic                 up_less;
  logic [IDX_W-1:0]     parent_idx;
  logic [CH_W-1:0]      l_idx;
  logic [CH_W-1:0]      r_idx;
  logic                 l_in;
  logic                 r_in;
  logic                 pick_b;
  logic [ENTRY_W-1:0]   pick_entry;
  logic [CH_W-1:0]      pick_idx;
  logic                 dn_less;
  logic signed [SCORE_BITS-1:0] res_score;

  assign accept  = start && (state == ST_IDLE);
  assign fn_in   = func_t'(func);
  assign item_in = {item_score[SCORE_BITS-1:0], item_value[TAG_BITS-1:0]};

  assign full  = (LCMP_W'(count) >= LCMP_W'(limit)) || (count >= CNT_W'(CAPACITY));
  assign empty = (count == '0);
  assign oob   = (ICMP_W'(entry_index) >= ICMP_W'(count));

  assign cur_score = cur[ENTRY_W-1 -: SCORE_BITS];
  assign a_score   = rd_data_a[ENTRY_W-1 -: SCORE_BITS];
  assign b_score   = rd_data_b[ENTRY_W-1 -: SCORE_BITS];

  assign up_less    = cur_score < a_score;
  assign parent_idx = IDX_W'((at - IDX_W'(1)) >> 1);

  assign l_idx      = CH_W'({at, 1'b1});
  assign r_idx      = l_idx + CH_W'(1);
  assign l_in       = l_idx < CH_W'(count);
  assign r_in       = r_idx < CH_W'(count);
  assign pick_b     = r_in && (b_score < a_score);
  assign pick_entry = pick_b ? rd_data_b : rd_data_a;
  assign pick_idx   = pick_b ? r_idx : l_idx;
  assign pick_score = pick_entry[ENTRY_W-1 -: SCORE_BITS];
  assign dn_less    = pick_score < cur_score;

  always_comb begin
    count_next = count;
    if (accept) begin
      case (fn_in)
        FN_PUSH: begin
          if (!full) begin
            count_next = count + CNT_W'(1);
          end
        end
        FN_POP: begin
          if (!empty) begin
            count_next = count - CNT_W'(1);
          end
        end
        default: begin
          count_next = count;
        end
      endcase
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (start) begin
          case (fn_in)
            FN_PUSH:    state_next = full ? ST_RESP : ST_UP_RD;
            FN_POP:     state_next = empty ? ST_RESP : ST_ROOT_RD;
            FN_PUSHPOP: state_next = empty ? ST_RESP : ST_ROOT_RD;
            FN_PEEK:    state_next = empty ? ST_RESP : ST_ROOT_RD;
            FN_LOOKUP:  state_next = oob ? ST_RESP : ST_ROOT_RD;
            default:    state_next = ST_RESP;
          endcase
        end
      end
      ST_ROOT_RD: state_next = ST_ROOT_LD;
      ST_ROOT_LD: begin
        case (fn)
          FN_POP:     state_next = empty ? ST_RESP : ST_DN_RD;
          FN_PUSHPOP: state_next = ST_DN_RD;
          default:    state_next = ST_RESP;
        endcase
      end
      ST_UP_RD:  state_next = (at == '0) ? ST_RESP : ST_UP_CMP;
      ST_UP_CMP: state_next = up_less ? ST_UP_RD : ST_RESP;
      ST_DN_RD:  state_next = l_in ? ST_DN_CMP : ST_RESP;
      ST_DN_CMP: state_next = dn_less ? ST_DN_RD : ST_RESP;
      ST_RESP:   state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    busy      = (state != ST_IDLE);
    done      = (state == ST_RESP);
    cfg_ready = 1'b1;
    wr_en     = 1'b0;
    wr_addr   = at;
    wr_data   = cur;
    rd_addr_a = '0;
    rd_addr_b = count[IDX_W-1:0];
    case (state)
      ST_ROOT_RD: begin
        rd_addr_a = (fn == FN_LOOKUP) ? IDX_W'(idx) : '0;
      end
      ST_UP_RD: begin
        rd_addr_a = parent_idx;
        wr_en     = (at == '0);
      end
      ST_UP_CMP: begin
        wr_en   = 1'b1;
        wr_data = up_less ? rd_data_a : cur;
      end
      ST_DN_RD: begin
        rd_addr_a = l_idx[IDX_W-1:0];
        rd_addr_b = r_idx[IDX_W-1:0];
        wr_en     = !l_in;
      end
      ST_DN_CMP: begin
        wr_en   = 1'b1;
        wr_data = dn_less ? pick_entry : cur;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
      limit <= LIMIT_RESET;
    end else begin
      state <= state_next;
      count <= count_next;
      if (cfg_valid) begin
        limit <= capacity_limit;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (start) begin
          fn         <= fn_in;
          item       <= item_in;
          idx        <= entry_index;
          res_entry  <= '0;
          cur        <= item_in;
          at         <= count[IDX_W-1:0];
          case (fn_in)
            FN_PUSH:    res_status <= full ? STAT_OVERFLOW : STAT_OK;
            FN_POP:     res_status <= empty ? STAT_UNDERFLOW : STAT_OK;
            FN_PUSHPOP: res_status <= empty ? STAT_UNDERFLOW : STAT_OK;
            FN_PEEK:    res_status <= empty ? STAT_UNDERFLOW : STAT_OK;
            FN_LOOKUP:  res_status <= oob ? STAT_RANGE : STAT_OK;
            default:    res_status <= STAT_OK;
          endcase
        end
      end
      ST_ROOT_LD: begin
        res_entry <= rd_data_a;
        at        <= '0;
        cur       <= (fn == FN_POP) ? rd_data_b : item;
      end
      ST_UP_CMP: begin
        if (up_less) begin
          at <= parent_idx;
        end
      end
      ST_DN_CMP: begin
        if (dn_less) begin
          at <= pick_idx[IDX_W-1:0];
        end
      end
      default: begin
        at <= at;
      end
    endcase
  end

  assign res_score   = res_entry[ENTRY_W-1 -: SCORE_BITS];
  assign status      = res_status;
  assign out_value   = VALUE_W'(res_entry[TAG_BITS-1:0]);
  assign out_score   = SCORE_W'(res_score);
  assign entry_count = COUNT_W'(count);

endmodule

// ===== rtl/binary_min_heap_queue_top.sv =====
`timescale 1ns / 1ps
// Top level of the binary min-heap priority queue.
//
// A request is taken when start is high while busy is low, and its single
// result beat appears on the result ports for one cycle with done high; the
// receiver cannot stall, so it must capture the beat in that cycle. Peek and
// lookup read one entry and answer. Push writes the new entry at the end and
// sifts it up level by level. Pop and pushpop take the root, put the last
// entry (pop) or the new item (pushpop) in its place and sift it down level
// by level; a pop that empties the heap answers without sifting. Each level
// is one read of the heap memory and one compare-and-write back. Errors and
// unused function codes go straight to the response state. The memory needs
// no clearing after reset, and capacity_limit is written through its own
// channel; the user must write it only while the block is idle, which the
// block itself does not enforce.
module binary_min_heap_queue_top import bmhq_pkg::*; #(
  parameter int CAPACITY   = CAPACITY_DEF,
  parameter int SCORE_BITS = SCORE_BITS_DEF,
  parameter int TAG_BITS   = TAG_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  logic [FUNC_W-1:0]         func,
  input  logic [VALUE_W-1:0]        item_value,
  input  logic signed [SCORE_W-1:0] item_score,
  input  logic [INDEX_W-1:0]        entry_index,
  output logic                      done,
  output logic [STATUS_W-1:0]       status,
  output logic [VALUE_W-1:0]        out_value,
  output logic signed [SCORE_W-1:0] out_score,
  output logic [COUNT_W-1:0]        entry_count,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [LIMIT_W-1:0]        capacity_limit
);

  localparam int ENTRY_W = SCORE_BITS + TAG_BITS;
  localparam int IDX_W   = $clog2(CAPACITY);

  logic               wr_en;
  logic [IDX_W-1:0]   wr_addr;
  logic [ENTRY_W-1:0] wr_data;
  logic [IDX_W-1:0]   rd_addr_a;
  logic [IDX_W-1:0]   rd_addr_b;
  logic [ENTRY_W-1:0] rd_data_a;
  logic [ENTRY_W-1:0] rd_data_b;

  bmhq_ctrl #(
    .CAPACITY   (CAPACITY),
    .SCORE_BITS (SCORE_BITS),
    .TAG_BITS   (TAG_BITS)
  ) u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .func           (func),
    .item_value     (item_value),
    .item_score     (item_score),
    .entry_index    (entry_index),
    .done           (done),
    .status         (status),
    .out_value      (out_value),
    .out_score      (out_score),
    .entry_count    (entry_count),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .capacity_limit (capacity_limit),
    .wr_en          (wr_en),
    .wr_addr        (wr_addr),
    .wr_data        (wr_data),
    .rd_addr_a      (rd_addr_a),
    .rd_addr_b      (rd_addr_b),
    .rd_data_a      (rd_data_a),
    .rd_data_b      (rd_data_b)
  );

  bmhq_store #(
    .DEPTH (CAPACITY),
    .WIDTH (ENTRY_W)
  ) u_store (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_addr_a (rd_addr_a),
    .rd_addr_b (rd_addr_b),
    .rd_data_a (rd_data_a),
    .rd_data_b (rd_data_b)
  );

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the binary min-heap priority queue top level.
module testbench;
  import bmhq_pkg::*;

  localparam int HEAP_DEPTH  = CAPACITY_DEF;
  localparam int FILL_DEPTH  = 48;
  localparam int CYCLE_LIMIT = 600000;

  localparam logic [FUNC_W-1:0] FN_SPARE_LO = 3'd5;
  localparam logic [FUNC_W-1:0] FN_SPARE_HI = 3'd7;

  typedef struct packed {
    status_t                  st;
    logic [VALUE_W-1:0]       val;
    logic signed [SCORE_W-1:0] scr;
    logic [COUNT_W-1:0]       cnt;
  } heap_reply_t;

  typedef struct {
    bit                        is_cfg;
    logic [FUNC_W-1:0]         f;
    logic [VALUE_W-1:0]        v;
    logic signed [SCORE_W-1:0] s;
    logic [INDEX_W-1:0]        idx;
    bit                        typed;
    heap_reply_t               want;
  } step_row_t;

  logic                      clk;
  logic                      rst;
  logic                      start;
  logic                      busy;
  logic [FUNC_W-1:0]         func;
  logic [VALUE_W-1:0]        item_value;
  logic signed [SCORE_W-1:0] item_score;
  logic [INDEX_W-1:0]        entry_index;
  logic                      done;
  logic [STATUS_W-1:0]       status;
  logic [VALUE_W-1:0]        out_value;
  logic signed [SCORE_W-1:0] out_score;
  logic [COUNT_W-1:0]        entry_count;
  logic                      cfg_valid;
  logic                      cfg_ready;
  logic [LIMIT_W-1:0]        capacity_limit;

  logic signed [SCORE_W-1:0] model_score [HEAP_DEPTH];
  logic [VALUE_W-1:0]        model_tag [HEAP_DEPTH];
  int unsigned               model_count;
  logic [LIMIT_W-1:0]        model_limit;

  heap_reply_t pending_replies [$];
  step_row_t   plan [$];
  int          mismatches;
  int unsigned cycle_no;

  binary_min_heap_queue_top dut (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .func           (func),
    .item_value     (item_value),
    .item_score     (item_score),
    .entry_index    (entry_index),
    .done           (done),
    .status         (status),
    .out_value      (out_value),
    .out_score      (out_score),
    .entry_count    (entry_count),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .capacity_limit (capacity_limit)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  task automatic note_mismatch(string field, logic [63:0] got, logic [63:0] want);
    mismatches++;
    $display("mismatch in %s at cycle %0d: got %h, want %h", field, cycle_no, got, want);
  endtask

  function automatic void swap_entries(int unsigned a, int unsigned b);
    logic signed [SCORE_W-1:0] ts;
    logic [VALUE_W-1:0]        tt;
    ts = model_score[a];
    tt = model_tag[a];
    model_score[a] = model_score[b];
    model_tag[a]   = model_tag[b];
    model_score[b] = ts;
    model_tag[b]   = tt;
  endfunction

  function automatic heap_reply_t heap_serve(logic [FUNC_W-1:0] f, logic [VALUE_W-1:0] v,
                                             logic signed [SCORE_W-1:0] s,
                                             logic [INDEX_W-1:0] idx);
    heap_reply_t r;
    int unsigned lim;
    int unsigned at;
    int unsigned up;
    int unsigned l;
    int unsigned rc;
    int unsigned pick;
    r.st  = STAT_OK;
    r.val = '0;
    r.scr = '0;
    lim = (model_limit > HEAP_DEPTH) ? HEAP_DEPTH : model_limit;
    case (f)
      FN_PUSH: begin
        if (model_count >= lim) begin
          r.st = STAT_OVERFLOW;
        end else begin
          at = model_count;
          model_score[at] = s;
          model_tag[at]   = v;
          while (at != 0) begin
            up = (at - 1) / 2;
            if (!(model_score[at] < model_score[up])) break;
            swap_entries(at, up);
            at = up;
          end
          model_count++;
        end
      end
      FN_POP, FN_PUSHPOP: begin
        if (model_count == 0) begin
          r.st = STAT_UNDERFLOW;
        end else begin
          r.val = model_tag[0];
          r.scr = model_score[0];
          if (f == FN_POP) begin
            model_count--;
            model_score[0] = model_score[model_count];
            model_tag[0]   = model_tag[model_count];
          end else begin
            model_score[0] = s;
            model_tag[0]   = v;
          end
          at = 0;
          while (2 * at + 1 < model_count) begin
            l    = 2 * at + 1;
            rc   = l + 1;
            pick = l;
            if (rc < model_count && model_score[rc] < model_score[l]) pick = rc;
            if (!(model_score[pick] < model_score[at])) break;
            swap_entries(at, pick);
            at = pick;
          end
        end
      end
      FN_PEEK: begin
        if (model_count == 0) begin
          r.st = STAT_UNDERFLOW;
        end else begin
          r.val = model_tag[0];
          r.scr = model_score[0];
        end
      end
      FN_LOOKUP: begin
        if (idx >= model_count) begin
          r.st = STAT_RANGE;
        end else begin
          r.val = model_tag[idx];
          r.scr = model_score[idx];
        end
      end
      default: begin
      end
    endcase
    r.cnt = model_count[COUNT_W-1:0];
    return r;
  endfunction

  function automatic step_row_t row_req(logic [FUNC_W-1:0] f, logic [VALUE_W-1:0] v,
                                        logic signed [SCORE_W-1:0] s,
                                        logic [INDEX_W-1:0] idx);
    step_row_t r;
    r.is_cfg   = 1'b0;
    r.f        = f;
    r.v        = v;
    r.s        = s;
    r.idx      = idx;
    r.typed    = 1'b0;
    r.want.st  = STAT_OK;
    r.want.val = '0;
    r.want.scr = '0;
    r.want.cnt = '0;
    return r;
  endfunction

  function automatic step_row_t row_chk(logic [FUNC_W-1:0] f, logic [VALUE_W-1:0] v,
                                        logic signed [SCORE_W-1:0] s,
                                        logic [INDEX_W-1:0] idx, status_t st,
                                        logic [VALUE_W-1:0] wv,
                                        logic signed [SCORE_W-1:0] ws,
                                        logic [COUNT_W-1:0] wc);
    step_row_t r;
    r = row_req(f, v, s, idx);
    r.typed    = 1'b1;
    r.want.st  = st;
    r.want.val = wv;
    r.want.scr = ws;
    r.want.cnt = wc;
    return r;
  endfunction

  function automatic step_row_t row_cfg(logic [LIMIT_W-1:0] lim);
    step_row_t r;
    r = row_req(FN_PUSH, '0, '0, '0);
    r.is_cfg = 1'b1;
    r.v      = VALUE_W'(lim);
    return r;
  endfunction

  function automatic logic signed [SCORE_W-1:0] pick_score();
    case ($urandom_range(9, 0))
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      2, 3, 4: return $signed($urandom_range(6, 0)) - 3;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_request(logic [FUNC_W-1:0] f, logic [VALUE_W-1:0] v,
                              logic signed [SCORE_W-1:0] s, logic [INDEX_W-1:0] idx,
                              bit typed, heap_reply_t want);
    heap_reply_t predicted;
    @(negedge clk);
    start       = 1'b1;
    func        = f;
    item_value  = v;
    item_score  = s;
    entry_index = idx;
    do @(posedge clk); while (busy);
    predicted = heap_serve(f, v, s, idx);
    pending_replies.push_back(typed ? want : predicted);
  endtask

  task automatic rest(int n);
    repeat (n) begin
      @(negedge clk);
      start = 1'b0;
    end
  endtask

  task automatic maybe_idle(int pct);
    if ($urandom_range(99, 0) < pct) rest($urandom_range(26, 1));
  endtask

  task automatic drain();
    @(negedge clk);
    start = 1'b0;
    while (pending_replies.size() != 0 || busy) @(negedge clk);
  endtask

  task automatic write_limit(logic [LIMIT_W-1:0] lim);
    drain();
    cfg_valid      = 1'b1;
    capacity_limit = lim;
    do @(posedge clk); while (!cfg_ready);
    model_limit = lim;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic random_request();
    heap_reply_t       none;
    logic [FUNC_W-1:0]  f;
    logic [INDEX_W-1:0] idx;
    int unsigned        roll;
    none = '0;
    roll = $urandom_range(99, 0);
    if (roll < 36) f = FN_PUSH;
    else if (roll < 56) f = FN_POP;
    else if (roll < 70) f = FN_PUSHPOP;
    else if (roll < 80) f = FN_PEEK;
    else if (roll < 95) f = FN_LOOKUP;
    else f = FUNC_W'($urandom_range(FN_SPARE_HI, FN_SPARE_LO));
    if (model_count != 0 && $urandom_range(3, 0) != 0) begin
      idx = INDEX_W'($urandom_range(model_count - 1, 0));
    end else begin
      idx = INDEX_W'($urandom);
    end
    send_request(f, $urandom, pick_score(), idx, 1'b0, none);
  endtask

  task automatic random_phase(logic [LIMIT_W-1:0] lim, int idle_pct, int items);
    write_limit(lim);
    repeat (items) begin
      random_request();
      maybe_idle(idle_pct);
      if ($urandom_range(49, 0) == 0) drain();
    end
  endtask

  always @(posedge clk) begin : check_beat
    heap_reply_t want;
    if (!rst && done) begin
      if (pending_replies.size() == 0) begin
        note_mismatch("beat with no request pending", 64'(status), 64'(STAT_OK));
      end else begin
        want = pending_replies.pop_front();
        if (status !== want.st) note_mismatch("status", 64'(status), 64'(want.st));
        if (out_value !== want.val) note_mismatch("out_value", 64'(out_value), 64'(want.val));
        if (out_score !== want.scr) note_mismatch("out_score", 64'(out_score), 64'(want.scr));
        if (entry_count !== want.cnt) begin
          note_mismatch("entry_count", 64'(entry_count), 64'(want.cnt));
        end
      end
    end
  end

  initial begin
    cycle_no = 0;
    while (cycle_no < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_no++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    heap_reply_t none;
    none           = '0;
    mismatches     = 0;
    rst            = 1'b1;
    start          = 1'b0;
    func           = FN_PUSH;
    item_value     = '0;
    item_score     = '0;
    entry_index    = '0;
    cfg_valid      = 1'b0;
    capacity_limit = LIMIT_RESET;
    model_count    = 0;
    model_limit    = LIMIT_RESET;

    plan.push_back(row_chk(FN_POP, 0, 0, 0, STAT_UNDERFLOW, 0, 0, 0));
    plan.push_back(row_chk(FN_PEEK, 0, 0, 0, STAT_UNDERFLOW, 0, 0, 0));
    plan.push_back(row_chk(FN_PUSHPOP, 32'hdead_beef, 42, 0, STAT_UNDERFLOW, 0, 0, 0));
    plan.push_back(row_chk(FN_LOOKUP, 0, 0, 0, STAT_RANGE, 0, 0, 0));
    plan.push_back(row_chk(FN_SPARE_LO, 0, 0, 0, STAT_OK, 0, 0, 0));
    plan.push_back(row_cfg(11'd0));
    plan.push_back(row_chk(FN_PUSH, 32'h1234_5678, 1, 0, STAT_OVERFLOW, 0, 0, 0));
    plan.push_back(row_cfg(11'd2047));
    plan.push_back(row_chk(FN_PUSH, 32'hffff_ffff, 32'sh7fff_ffff, 0, STAT_OK, 0, 0, 1));
    plan.push_back(row_chk(FN_PUSH, 32'h0, 32'sh8000_0000, 0, STAT_OK, 0, 0, 2));
    plan.push_back(row_chk(FN_PEEK, 0, 0, 0, STAT_OK, 32'h0, 32'sh8000_0000, 2));
    plan.push_back(row_chk(FN_LOOKUP, 0, 0, 1, STAT_OK, 32'hffff_ffff, 32'sh7fff_ffff, 2));
    plan.push_back(row_chk(FN_LOOKUP, 0, 0, 10'h3ff, STAT_RANGE, 0, 0, 2));
    // Two equal children below a larger parent after the pop.
    plan.push_back(row_req(FN_PUSH, 32'h11, 5, 0));
    plan.push_back(row_req(FN_PUSH, 32'h22, 5, 0));
    plan.push_back(row_req(FN_PUSH, 32'h33, 9, 0));
    plan.push_back(row_req(FN_POP, 0, 0, 0));
    plan.push_back(row_req(FN_LOOKUP, 0, 0, 0));
    plan.push_back(row_req(FN_LOOKUP, 0, 0, 1));
    plan.push_back(row_req(FN_PUSHPOP, 32'h44, 32'sh7fff_ffff, 0));
    plan.push_back(row_req(FN_SPARE_HI, 32'hffff_ffff, -1, 10'h3ff));
    // The limit drops below the number of held entries.
    plan.push_back(row_cfg(11'd3));
    plan.push_back(row_chk(FN_PUSH, 32'h55, 0, 0, STAT_OVERFLOW, 0, 0, 4));
    plan.push_back(row_req(FN_POP, 0, 0, 0));
    plan.push_back(row_cfg(11'd1024));
    plan.push_back(row_req(FN_PUSH, 32'h66, -1, 0));

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        write_limit(plan[i].v[LIMIT_W-1:0]);
      end else begin
        send_request(plan[i].f, plan[i].v, plan[i].s, plan[i].idx, plan[i].typed, plan[i].want);
        maybe_idle(34);
      end
    end

    random_phase(11'd64, 34, 110);
    random_phase(11'd1, 83, 110);
    random_phase(11'd2047, 0, 110);

    // Grow the heap under the clamped limit, then empty it in order.
    while (model_count < FILL_DEPTH) begin
      send_request(FN_PUSH, $urandom, pick_score(), 0, 1'b0, none);
      if ($urandom_range(31, 0) == 0) begin
        send_request(FN_LOOKUP, 0, 0, INDEX_W'($urandom), 1'b0, none);
      end
    end
    send_request(FN_PUSH, $urandom, pick_score(), 0, 1'b0, none);
    send_request(FN_LOOKUP, 0, 0, 10'h3ff, 1'b0, none);
    send_request(FN_PUSHPOP, $urandom, pick_score(), 0, 1'b0, none);
    while (model_count != 0) send_request(FN_POP, 0, 0, 0, 1'b0, none);
    send_request(FN_POP, 0, 0, 0, 1'b0, none);

    drain();
    repeat (40) @(posedge clk);
    if (pending_replies.size() != 0) begin
      note_mismatch("replies never seen", 64'(pending_replies.size()), 0);
    end
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/bmhq_pkg.sv
rtl/bmhq_store.sv
rtl/bmhq_ctrl.sv
rtl/binary_min_heap_queue_top.sv
tb/sv/testbench.sv
